FILE: design/pcv_pkg.sv
// Shared types and codes for the point cloud voxelizer.
// No dependencies; imported by the controller, the datapath and the top level.
package pcv_pkg;

  localparam int unsigned FEAT_W  = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned CNT_W   = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Command codes carried in the input tuser
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Reduction modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_MEAN = 2'd1;
  localparam logic [1:0] MODE_MAX  = 2'd2;
  localparam logic [1:0] MODE_MIN  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [2:0] REG_INV_X      = 3'd3;
  localparam logic [2:0] REG_INV_Y      = 3'd4;
  localparam logic [2:0] REG_INV_Z      = 3'd5;
  localparam logic [2:0] REG_MODE       = 3'd6;
  localparam logic [2:0] REG_MAX_POINTS = 3'd7;

  // Grid axes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_EXIST     = 3'd1,
    ST_COUNTED   = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_FULL      = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_READ_NONE = 3'd6,
    ST_CLEARED   = 3'd7
  } status_e;

  typedef struct packed {
    logic       load;
    logic       set_clear;
    logic       grid_mul;
    logic [1:0] axis;
    logic       scan_start;
    logic       scan_run;
    logic       set_outside;
    logic       set_full;
    logic       alloc;
    logic       update;
    logic       rd_addr;
    logic       rd_unalloc;
    logic       rd_load;
    logic       rep_direct;
    logic       div_start;
    logic       div_store;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_clear;
    logic outside;
    logic hit;
    logic miss;
    logic full;
    logic sel_ok;
    logic mean;
    logic div_done;
    logic last_feat;
  } dp_sts_t;

endpackage

FILE: design/pcv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pcv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pcv_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; used by the datapath for mean reduction.
module pcv_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic [DW:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/pcv_ctrl.sv
// Controller state machine for the voxelizer: sequences grid mapping, table
// scan, update, read, clear and reduction. Depends on pcv_pkg.
module pcv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  pcv_pkg::dp_sts_t  sts_i,
  output pcv_pkg::dp_cmd_t  cmd_o
);
  import pcv_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DISPATCH = 15'b000000000000010,
    S_GRID1    = 15'b000000000000100,
    S_GRID2    = 15'b000000000001000,
    S_GRID3    = 15'b000000000010000,
    S_CHECK    = 15'b000000000100000,
    S_SCAN     = 15'b000000001000000,
    S_FETCH    = 15'b000000010000000,
    S_UPDATE   = 15'b000000100000000,
    S_RDCHK    = 15'b000001000000000,
    S_RDWAIT   = 15'b000010000000000,
    S_REPORT   = 15'b000100000000000,
    S_DIVWAIT  = 15'b001000000000000,
    S_DONE     = 15'b010000000000000,
    S_SPARE    = 15'b100000000000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    state_d   = state_q;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.is_clear) begin
          cmd_o.set_clear = 1'b1;
          state_d         = S_DONE;
        end else if (sts_i.is_insert) begin
          cmd_o.grid_mul = 1'b1;
          cmd_o.axis     = AXIS_X;
          state_d        = S_GRID1;
        end else begin
          state_d = S_RDCHK;
        end
      end
      S_GRID1: begin
        cmd_o.grid_mul = 1'b1;
        cmd_o.axis     = AXIS_Y;
        state_d        = S_GRID2;
      end
      S_GRID2: begin
        cmd_o.grid_mul = 1'b1;
        cmd_o.axis     = AXIS_Z;
        state_d        = S_GRID3;
      end
      S_GRID3: state_d = S_CHECK;
      S_CHECK: begin
        if (sts_i.outside) begin
          cmd_o.set_outside = 1'b1;
          state_d           = S_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.hit) begin
          state_d = S_FETCH;
        end else if (sts_i.miss) begin
          if (sts_i.full) begin
            cmd_o.set_full = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.alloc = 1'b1;
            state_d     = S_UPDATE;
          end
        end
      end
      S_FETCH: state_d = S_UPDATE;
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_REPORT;
      end
      S_RDCHK: begin
        if (sts_i.sel_ok) begin
          cmd_o.rd_addr = 1'b1;
          state_d       = S_RDWAIT;
        end else begin
          cmd_o.rd_unalloc = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_RDWAIT: begin
        cmd_o.rd_load = 1'b1;
        state_d       = S_REPORT;
      end
      S_REPORT: begin
        if (sts_i.mean) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVWAIT;
        end else begin
          cmd_o.rep_direct = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DIVWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d         = sts_i.last_feat ? S_DONE : S_REPORT;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

FILE: design/pcv_dp.sv
// Datapath for the voxelizer: configuration registers, grid multiplier,
// coordinate table scan, count and feature memories, divider and result
// registers. Depends on pcv_pkg, pcv_ram and pcv_div.
module pcv_dp #(
  parameter int unsigned MAX_VOXELS   = 4096,
  parameter int unsigned GRID_X       = 512,
  parameter int unsigned GRID_Y       = 512,
  parameter int unsigned GRID_Z       = 32,
  parameter int unsigned MAX_SLOTS    = 32,
  parameter int unsigned NUM_FEATURES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [1:0]        in_command_i,
  input  logic [31:0]       in_pos_x_i,
  input  logic [31:0]       in_pos_y_i,
  input  logic [31:0]       in_pos_z_i,
  input  logic [31:0]       in_intensity_i,
  input  logic [11:0]       in_voxel_select_i,
  input  pcv_pkg::dp_cmd_t  cmd_i,
  output pcv_pkg::dp_sts_t  sts_o,
  output logic [2:0]        out_status_o,
  output logic [11:0]       out_voxel_index_o,
  output logic [4:0]        out_slot_o,
  output logic [8:0]        out_coord_x_o,
  output logic [8:0]        out_coord_y_o,
  output logic [4:0]        out_coord_z_o,
  output logic [15:0]       out_point_count_o,
  output logic [31:0]       out_agg_x_o,
  output logic [31:0]       out_agg_y_o,
  output logic [31:0]       out_agg_z_o,
  output logic [31:0]       out_agg_intensity_o,
  output logic [12:0]       out_voxel_total_o
);
  import pcv_pkg::*;

  localparam int unsigned KEPT = (NUM_FEATURES < 4) ? NUM_FEATURES : 4;
  localparam int unsigned AW   = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
  localparam int unsigned IW   = $clog2(MAX_VOXELS + 1);
  localparam int unsigned XW   = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int unsigned YW   = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int unsigned ZW   = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam int unsigned KW   = XW + YW + ZW;
  localparam int unsigned FRW  = ACC_W * KEPT;
  localparam int unsigned FIW  = (KEPT > 1) ? $clog2(KEPT) : 1;

  function automatic logic [31:0] sat_acc(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi, lo;
    logic [31:0] r;
    hi = 48'sh0000_7FFF_FFFF;
    lo = -48'sh0000_8000_0000;
    if (a > hi) begin
      r = 32'h7FFF_FFFF;
    end else if (a < lo) begin
      r = 32'h8000_0000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  // configuration
  logic [31:0] org_q [3];
  logic [31:0] inv_q [3];
  logic [1:0]  mode_q;
  logic [5:0]  maxp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        inv_q[i] <= 32'h0001_0000;
      end
      mode_q <= MODE_NONE;
      maxp_q <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X:   org_q[0] <= cfg_data_i;
        REG_ORIGIN_Y:   org_q[1] <= cfg_data_i;
        REG_ORIGIN_Z:   org_q[2] <= cfg_data_i;
        REG_INV_X:      inv_q[0] <= cfg_data_i;
        REG_INV_Y:      inv_q[1] <= cfg_data_i;
        REG_INV_Z:      inv_q[2] <= cfg_data_i;
        REG_MODE:       mode_q   <= cfg_data_i[1:0];
        REG_MAX_POINTS: maxp_q   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // latched input item
  logic [1:0]  kind_q;
  logic [31:0] pos_q [4];
  logic [11:0] sel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= in_command_i;
      pos_q[0] <= in_pos_x_i;
      pos_q[1] <= in_pos_y_i;
      pos_q[2] <= in_pos_z_i;
      pos_q[3] <= in_intensity_i;
      sel_q    <= in_voxel_select_i;
    end
  end

  // grid mapping: multiply one axis per cycle, range check in the cycle after its multiply
  logic [32:0] diff;
  logic [63:0] prod;
  logic        pv_q, pneg_q, pinvz_q, outside_q;
  logic [1:0]  pa_q;
  logic [31:0] phi_q, qq, lim;
  logic        bad;
  logic [XW-1:0] cx_q;
  logic [YW-1:0] cy_q;
  logic [ZW-1:0] cz_q;
  logic [KW-1:0] key;

  always_comb begin
    diff = {pos_q[cmd_i.axis][31], pos_q[cmd_i.axis]} -
           {org_q[cmd_i.axis][31], org_q[cmd_i.axis]};
    prod = 64'(diff[31:0]) * 64'(inv_q[cmd_i.axis]);
    qq   = pneg_q ? 32'd0 : phi_q;
    case (pa_q)
      AXIS_X:  lim = 32'(GRID_X);
      AXIS_Y:  lim = 32'(GRID_Y);
      default: lim = 32'(GRID_Z);
    endcase
    bad = (pneg_q && !pinvz_q) || (qq >= lim);
    key = {cz_q, cy_q, cx_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q      <= 1'b0;
      outside_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.grid_mul;
      if (cmd_i.load) begin
        outside_q <= 1'b0;
      end else if (pv_q && bad) begin
        outside_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grid_mul) begin
      pa_q    <= cmd_i.axis;
      pneg_q  <= diff[32];
      pinvz_q <= (inv_q[cmd_i.axis] == 32'd0);
      phi_q   <= prod[63:32];
    end
    if (pv_q) begin
      case (pa_q)
        AXIS_X:  cx_q <= XW'(qq);
        AXIS_Y:  cy_q <= YW'(qq);
        default: cz_q <= ZW'(qq);
      endcase
    end
  end

  // coordinate table scan
  logic [IW-1:0] alloc_q, iss_q, piss_q;
  logic          pend_q, fresh_q;
  logic [AW-1:0] v_q, sel_addr, coord_raddr, vox_raddr;
  logic [KW-1:0] coord_rd;
  logic [CNT_W-1:0] cnt_rd;
  logic [FRW-1:0]   feat_rd;
  logic          hit, miss, full, sel_ok;

  always_comb begin
    sel_addr    = AW'(sel_q);
    coord_raddr = cmd_i.rd_addr ? sel_addr : iss_q[AW-1:0];
    vox_raddr   = cmd_i.rd_addr ? sel_addr : v_q;
    hit         = cmd_i.scan_run && pend_q && (coord_rd == key);
    miss        = cmd_i.scan_run && !pend_q && (iss_q >= alloc_q);
    full        = alloc_q >= IW'(MAX_VOXELS);
    sel_ok      = (32'(sel_q) < 32'(alloc_q)) && (32'(sel_q) < MAX_VOXELS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
      iss_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cmd_i.set_clear) begin
        alloc_q <= '0;
      end else if (cmd_i.alloc) begin
        alloc_q <= alloc_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        iss_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.scan_run && (iss_q < alloc_q)) begin
        iss_q  <= iss_q + 1'b1;
        pend_q <= 1'b1;
      end else begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run) begin
      piss_q <= iss_q;
    end
    if (hit) begin
      v_q     <= piss_q[AW-1:0];
      fresh_q <= 1'b0;
    end else if (cmd_i.alloc) begin
      v_q     <= alloc_q[AW-1:0];
      fresh_q <= 1'b1;
    end
  end

  // count and accumulator update
  logic [CNT_W-1:0] n, cnt_new;
  logic [ACC_W-1:0] acc_new [KEPT];
  logic [FRW-1:0]   feat_wr;
  logic [16:0]      slot_lim;
  logic             stored;

  always_comb begin
    logic signed [ACC_W-1:0] old_v, x;
    n       = fresh_q ? '0 : cnt_rd;
    cnt_new = (n != COUNT_MAX) ? n + 1'b1 : n;
    for (int d = 0; d < KEPT; d++) begin
      old_v = feat_rd[d*ACC_W +: ACC_W];
      x     = {{(ACC_W-FEAT_W){pos_q[d][31]}}, pos_q[d]};
      if (fresh_q) begin
        acc_new[d] = x;
      end else begin
        case (mode_q)
          MODE_MEAN: acc_new[d] = (n != COUNT_MAX) ? old_v + x : old_v;
          MODE_MAX:  acc_new[d] = (x > old_v) ? x : old_v;
          MODE_MIN:  acc_new[d] = (x < old_v) ? x : old_v;
          default:   acc_new[d] = old_v;
        endcase
      end
      feat_wr[d*ACC_W +: ACC_W] = acc_new[d];
    end
    slot_lim = (32'(maxp_q) < MAX_SLOTS) ? 17'(maxp_q) : 17'(MAX_SLOTS);
    stored   = {1'b0, n} < slot_lim;
  end

  pcv_ram #(.WIDTH(KW), .DEPTH(MAX_VOXELS)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.alloc),
    .waddr_i (alloc_q[AW-1:0]),
    .wdata_i (key),
    .raddr_i (coord_raddr),
    .rdata_o (coord_rd)
  );

  pcv_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VOXELS)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (v_q),
    .wdata_i (cnt_new),
    .raddr_i (vox_raddr),
    .rdata_o (cnt_rd)
  );

  pcv_ram #(.WIDTH(FRW), .DEPTH(MAX_VOXELS)) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (v_q),
    .wdata_i (feat_wr),
    .raddr_i (vox_raddr),
    .rdata_o (feat_rd)
  );

  // result registers
  status_e          res_status_q;
  logic [11:0]      res_vi_q;
  logic [4:0]       res_slot_q;
  logic [8:0]       res_cx_q, res_cy_q;
  logic [4:0]       res_cz_q;
  logic [CNT_W-1:0] res_cnt_q;
  logic [31:0]      res_agg_q [4];
  logic [ACC_W-1:0] rep_acc_q [KEPT];
  logic [FIW-1:0]   fi_q;

  // mean: divide magnitude, then restore sign and saturate
  logic [ACC_W-1:0] cur_acc, div_mag, quo;
  logic             cur_neg, div_done;
  logic [31:0]      mean_sat;

  always_comb begin
    cur_acc = rep_acc_q[fi_q];
    cur_neg = cur_acc[ACC_W-1];
    div_mag = cur_neg ? (~cur_acc + 1'b1) : cur_acc;
    if (cur_neg) begin
      mean_sat = (quo > 48'h0000_8000_0000) ? 32'h8000_0000 : (~quo[31:0] + 1'b1);
    end else begin
      mean_sat = (quo > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
    end
  end

  pcv_div #(.NW(ACC_W), .DW(CNT_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_mag),
    .divisor_i  (res_cnt_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_status_q <= ST_CLEARED;
      res_vi_q     <= '0;
      res_slot_q   <= '0;
      res_cx_q     <= '0;
      res_cy_q     <= '0;
      res_cz_q     <= '0;
      res_cnt_q    <= '0;
      fi_q         <= '0;
      for (int d = 0; d < 4; d++) begin
        res_agg_q[d] <= '0;
      end
    end
    if (cmd_i.set_clear) begin
      res_status_q <= ST_CLEARED;
    end
    if (cmd_i.set_outside) begin
      res_status_q <= ST_OUTSIDE;
    end
    if (cmd_i.set_full) begin
      res_status_q <= ST_FULL;
      res_cx_q     <= 9'(cx_q);
      res_cy_q     <= 9'(cy_q);
      res_cz_q     <= 5'(cz_q);
    end
    if (cmd_i.update) begin
      if (stored) begin
        res_status_q <= fresh_q ? ST_NEW : ST_EXIST;
        res_slot_q   <= n[4:0];
      end else begin
        res_status_q <= ST_COUNTED;
        res_slot_q   <= '0;
      end
      res_vi_q  <= 12'(v_q);
      res_cx_q  <= 9'(cx_q);
      res_cy_q  <= 9'(cy_q);
      res_cz_q  <= 5'(cz_q);
      res_cnt_q <= cnt_new;
      for (int d = 0; d < KEPT; d++) begin
        rep_acc_q[d] <= acc_new[d];
      end
    end
    if (cmd_i.rd_unalloc) begin
      res_status_q <= ST_READ_NONE;
      res_vi_q     <= sel_q;
    end
    if (cmd_i.rd_load) begin
      res_status_q <= ST_READ_OK;
      res_vi_q     <= sel_q;
      res_cx_q     <= 9'(coord_rd[XW-1:0]);
      res_cy_q     <= 9'(coord_rd[XW+YW-1:XW]);
      res_cz_q     <= 5'(coord_rd[KW-1:XW+YW]);
      res_cnt_q    <= cnt_rd;
      for (int d = 0; d < KEPT; d++) begin
        rep_acc_q[d] <= feat_rd[d*ACC_W +: ACC_W];
      end
    end
    if (cmd_i.rep_direct) begin
      for (int d = 0; d < KEPT; d++) begin
        res_agg_q[d] <= (mode_q == MODE_NONE) ? 32'd0 : sat_acc(rep_acc_q[d]);
      end
    end
    if (cmd_i.div_store) begin
      res_agg_q[fi_q] <= mean_sat;
      fi_q            <= fi_q + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_o        <= res_status_q;
      out_voxel_index_o   <= res_vi_q;
      out_slot_o          <= res_slot_q;
      out_coord_x_o       <= res_cx_q;
      out_coord_y_o       <= res_cy_q;
      out_coord_z_o       <= res_cz_q;
      out_point_count_o   <= res_cnt_q;
      out_agg_x_o         <= res_agg_q[0];
      out_agg_y_o         <= res_agg_q[1];
      out_agg_z_o         <= res_agg_q[2];
      out_agg_intensity_o <= res_agg_q[3];
      out_voxel_total_o   <= 13'(alloc_q);
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.is_insert = (kind_q == CMD_INSERT);
    sts_o.is_clear  = (kind_q == CMD_CLEAR);
    sts_o.outside   = outside_q;
    sts_o.hit       = hit;
    sts_o.miss      = miss;
    sts_o.full      = full;
    sts_o.sel_ok    = sel_ok;
    sts_o.mean      = (mode_q == MODE_MEAN);
    sts_o.div_done  = div_done;
    sts_o.last_feat = (fi_q == FIW'(KEPT - 1));
  end

`ifndef SYNTH
  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_q <= IW'(MAX_VOXELS))
    else $error("allocated voxel count beyond table depth");

  a_hit_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hit && miss))
    else $error("scan reports hit and miss together");

  a_update_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (IW'(v_q) < alloc_q))
    else $error("update of an unallocated voxel");

  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |=> (alloc_q == $past(alloc_q) + 1'b1))
    else $error("allocation did not advance the voxel count");
`endif

endmodule

FILE: design/point_cloud_voxelizer.sv
// Point cloud voxelizer: one result per command. Insert scans the coordinate
// table linearly over the voxels already allocated, one entry per cycle; mean
// mode divides each feature in turn with the serial divider, for inserts that
// reach a voxel and for reads. Reset returns the configuration registers to
// defaults and empties the table; no clearing pass.
module point_cloud_voxelizer #(
  parameter int unsigned MAX_VOXELS   = 4096,
  parameter int unsigned GRID_X       = 512,
  parameter int unsigned GRID_Y       = 512,
  parameter int unsigned GRID_Z       = 32,
  parameter int unsigned MAX_SLOTS    = 32,
  parameter int unsigned NUM_FEATURES = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pos_x, pos_y, pos_z, intensity, voxel_select, zero pad
  input  logic [143:0] s_axis_tdata_i,
  // command
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // voxel_index, slot, coord_x, coord_y, coord_z, point_count,
  // agg_x, agg_y, agg_z, agg_intensity, voxel_total, zero pad
  output logic [199:0] m_axis_tdata_o,
  // status
  output logic [2:0]   m_axis_tuser_o
);
  import pcv_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [11:0] vi;
  logic [4:0]  slot, cz;
  logic [8:0]  cx, cy;
  logic [15:0] cnt;
  logic [31:0] ax, ay, az, ai;
  logic [12:0] total;

  pcv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pcv_dp #(
    .MAX_VOXELS   (MAX_VOXELS),
    .GRID_X       (GRID_X),
    .GRID_Y       (GRID_Y),
    .GRID_Z       (GRID_Z),
    .MAX_SLOTS    (MAX_SLOTS),
    .NUM_FEATURES (NUM_FEATURES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_command_i        (s_axis_tuser_i),
    .in_pos_x_i          (s_axis_tdata_i[31:0]),
    .in_pos_y_i          (s_axis_tdata_i[63:32]),
    .in_pos_z_i          (s_axis_tdata_i[95:64]),
    .in_intensity_i      (s_axis_tdata_i[127:96]),
    .in_voxel_select_i   (s_axis_tdata_i[139:128]),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_status_o        (m_axis_tuser_o),
    .out_voxel_index_o   (vi),
    .out_slot_o          (slot),
    .out_coord_x_o       (cx),
    .out_coord_y_o       (cy),
    .out_coord_z_o       (cz),
    .out_point_count_o   (cnt),
    .out_agg_x_o         (ax),
    .out_agg_y_o         (ay),
    .out_agg_z_o         (az),
    .out_agg_intensity_o (ai),
    .out_voxel_total_o   (total)
  );

  assign m_axis_tdata_o = {3'b000, total, ai, az, ay, ax, cnt, cz, cy, cx, slot, vi};

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for point_cloud_voxelizer: streams insert, read and clear
// commands through the block and compares every result with an in-bench prediction.
// Depends on pcv_pkg and the design top level.
module testbench;
  import pcv_pkg::*;

  localparam int NVOX = 4096;
  localparam int GX = 512;
  localparam int GY = 512;
  localparam int GZ = 32;
  localparam int NSLOT = 32;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] voxel_index;
    logic [4:0]  slot;
    logic [8:0]  coord_x;
    logic [8:0]  coord_y;
    logic [4:0]  coord_z;
    logic [15:0] point_count;
    logic [31:0] agg_x;
    logic [31:0] agg_y;
    logic [31:0] agg_z;
    logic [31:0] agg_i;
    logic [12:0] voxel_total;
  } voxel_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [199:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;

  point_cloud_voxelizer DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] org [3];
  logic [31:0] inv [3];
  logic [1:0]  mode;
  logic [5:0]  max_pts;
  logic [8:0]  tab_x [NVOX];
  logic [8:0]  tab_y [NVOX];
  logic [4:0]  tab_z [NVOX];
  int unsigned cnt_tab [NVOX];
  longint      acc_tab [NVOX][4];
  int unsigned n_alloc;

  voxel_result_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  int burst_left = 0;

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // floor((pos - origin) * inv) in Q32.32; returns -1 when off the grid
  function automatic int grid_index(logic [31:0] pos, int ax, int lim);
    longint diff;
    logic [127:0] prod;
    diff = longint'($signed(pos)) - longint'($signed(org[ax]));
    if (diff < 0) return (inv[ax] != 0) ? -1 : 0;
    prod = 128'(diff) * 128'(inv[ax]);
    if (prod[127:32] >= lim) return -1;
    return int'(prod[40:32]);
  endfunction

  function automatic void fill_voxel(int v, inout voxel_result_t r);
    r.coord_x = tab_x[v];
    r.coord_y = tab_y[v];
    r.coord_z = tab_z[v];
    r.point_count = cnt_tab[v][15:0];
    if (mode == MODE_NONE) begin
      r.agg_x = '0; r.agg_y = '0; r.agg_z = '0; r.agg_i = '0;
    end else if (mode == MODE_MEAN) begin
      r.agg_x = sat32(cnt_tab[v] ? acc_tab[v][0] / longint'(cnt_tab[v]) : 0);
      r.agg_y = sat32(cnt_tab[v] ? acc_tab[v][1] / longint'(cnt_tab[v]) : 0);
      r.agg_z = sat32(cnt_tab[v] ? acc_tab[v][2] / longint'(cnt_tab[v]) : 0);
      r.agg_i = sat32(cnt_tab[v] ? acc_tab[v][3] / longint'(cnt_tab[v]) : 0);
    end else begin
      r.agg_x = sat32(acc_tab[v][0]);
      r.agg_y = sat32(acc_tab[v][1]);
      r.agg_z = sat32(acc_tab[v][2]);
      r.agg_i = sat32(acc_tab[v][3]);
    end
  endfunction

  function automatic voxel_result_t predict_voxel(logic [1:0] cmd, logic [31:0] f [4],
                                                  logic [11:0] sel);
    voxel_result_t r;
    int cx, cy, cz, v, lim;
    int unsigned n;
    bit fresh;
    longint x;
    r = '0;
    fresh = 0;
    if (cmd == CMD_CLEAR) begin
      n_alloc = 0;
      r.status = ST_CLEARED;
      return r;
    end
    if (cmd != CMD_INSERT) begin
      r.voxel_index = sel;
      if (sel < n_alloc) begin
        r.status = ST_READ_OK;
        fill_voxel(sel, r);
      end else begin
        r.status = ST_READ_NONE;
      end
      r.voxel_total = 13'(n_alloc);
      return r;
    end
    cx = grid_index(f[0], 0, GX);
    cy = grid_index(f[1], 1, GY);
    cz = grid_index(f[2], 2, GZ);
    r.voxel_total = 13'(n_alloc);
    if (cx < 0 || cy < 0 || cz < 0) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    for (v = 0; v < n_alloc; v++)
      if (tab_x[v] == cx && tab_y[v] == cy && tab_z[v] == cz) break;
    if (v == n_alloc) begin
      if (n_alloc >= NVOX) begin
        r.status = ST_FULL;
        r.coord_x = cx; r.coord_y = cy; r.coord_z = cz;
        return r;
      end
      n_alloc++;
      tab_x[v] = cx; tab_y[v] = cy; tab_z[v] = cz;
      cnt_tab[v] = 0;
      fresh = 1;
    end
    n = cnt_tab[v];
    if (n < 65535) cnt_tab[v] = n + 1;
    for (int d = 0; d < 4; d++) begin
      x = longint'($signed(f[d]));
      if (fresh) acc_tab[v][d] = x;
      else if (mode == MODE_MEAN) begin
        if (n < 65535) acc_tab[v][d] += x;
      end else if (mode == MODE_MAX) begin
        if (x > acc_tab[v][d]) acc_tab[v][d] = x;
      end else if (mode == MODE_MIN) begin
        if (x < acc_tab[v][d]) acc_tab[v][d] = x;
      end
    end
    lim = (max_pts < NSLOT) ? max_pts : NSLOT;
    if (n < lim) begin
      r.status = fresh ? ST_NEW : ST_EXIST;
      r.slot = n[4:0];
    end else begin
      r.status = ST_COUNTED;
    end
    r.voxel_index = v[11:0];
    fill_voxel(v, r);
    r.voxel_total = 13'(n_alloc);
    return r;
  endfunction

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_ORIGIN_X: org[0] = val;
      REG_ORIGIN_Y: org[1] = val;
      REG_ORIGIN_Z: org[2] = val;
      REG_INV_X: inv[0] = val;
      REG_INV_Y: inv[1] = val;
      REG_INV_Z: inv[2] = val;
      REG_MODE: mode = val[1:0];
      default: max_pts = val[5:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(logic [31:0] ox, oy, oz, ix, iy, iz);
    wait_idle();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_X, ix);
    write_reg(REG_INV_Y, iy);
    write_reg(REG_INV_Z, iz);
  endtask

  task automatic set_reduce(logic [1:0] m, logic [5:0] mp);
    wait_idle();
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_MAX_POINTS, {26'd0, mp});
  endtask

  // Send one command; the sender works in bursts with random gaps between them
  task automatic send_cmd(logic [1:0] cmd, logic [31:0] px, py, pz, pi, logic [11:0] sel);
    logic [31:0] f [4];
    if (burst_left == 0) begin
      @(posedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    f[0] = px; f[1] = py; f[2] = pz; f[3] = pi;
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {12'd0, sel, pi, pz, py, px};
    expected_q.push_back(predict_voxel(cmd, f, sel));
    n_items++;
    do @(posedge clk_i); while (!s_axis_tready_o);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // point in voxel (x, y, z) for unit voxels at origin zero, random fraction
  task automatic send_in_voxel(int x, int y, int z, logic [31:0] pi);
    send_cmd(CMD_INSERT, {x[15:0], 16'($urandom)}, {y[15:0], 16'($urandom)},
             {z[15:0], 16'($urandom)}, pi, 12'($urandom));
  endtask

  task automatic test_directed();
    set_reduce(MODE_MAX, 6'd32);
    send_in_voxel(0, 0, 0, 32'h7FFFFFFF);
    send_in_voxel(0, 0, 0, 32'h80000000);
    send_in_voxel(511, 511, 31, 32'h0);
    send_cmd(CMD_INSERT, 32'h0200_0000, 0, 0, 0, 0);        // x off the top
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 0, 0, 0, 0);        // negative x
    send_cmd(CMD_INSERT, 0, 0, 32'h0020_0000, 0, 0);        // z off the top
    send_cmd(CMD_READ, 0, 0, 0, 0, 12'd0);
    send_cmd(CMD_READ, 0, 0, 0, 0, 12'd1);
    send_cmd(CMD_READ, 0, 0, 0, 0, 12'hFFF);                // unallocated
    send_cmd(2'd3, 0, 0, 0, 0, 12'd1);                      // decoded as a read
    set_reduce(MODE_MIN, 6'd1);
    send_in_voxel(0, 0, 0, 32'h5);
    send_in_voxel(0, 0, 0, 32'hFFFF_0000);
    set_reduce(MODE_MEAN, 6'd0);
    send_in_voxel(511, 511, 31, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 0, 0, 0, 0, 12'd1);
    set_reduce(MODE_NONE, 6'd63);
    send_in_voxel(0, 0, 0, 32'h1);
    send_cmd(CMD_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 12'hFFF);
    send_cmd(CMD_READ, 0, 0, 0, 0, 12'd0);
    // zero inverse size on x and y folds every coordinate, negative too, onto zero
    set_grid(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1234, 0);
    send_cmd(CMD_INSERT, 32'h0, 32'h0, 32'h0000_0001, 32'h1, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0);
    set_grid(0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
  endtask

  task automatic test_random(int n, logic [1:0] m, logic [5:0] mp);
    int k;
    set_reduce(m, mp);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70)
        send_in_voxel($urandom_range(0, 5), $urandom_range(0, 3), $urandom_range(0, 2),
                      $urandom);
      else if (k < 80)
        send_cmd(CMD_INSERT, $urandom, $urandom, $urandom, $urandom, 12'($urandom));
      else if (k < 95)
        send_cmd(2'($urandom_range(1, 3) | 1), $urandom, $urandom, $urandom, $urandom,
                 12'($urandom_range(0, 80)));
      else if (k < 98)
        send_cmd(CMD_READ, 0, 0, 0, 0, 12'($urandom));
      else
        send_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, 12'($urandom));
    end
  endtask

  // Fill many distinct voxels in a coarse grid to grow the table, then scatter
  task automatic test_coarse_grid();
    set_grid(32'hFFF0_0000, 32'h8000_0000, 32'hFFFF_0000,
             32'h0010_0000, 32'h0000_0400, 32'h0000_8000);
    set_reduce(MODE_MEAN, 6'd4);
    for (int i = 0; i < 60; i++)
      send_cmd(CMD_INSERT, $urandom, $urandom, $urandom, $urandom, 12'($urandom));
    for (int i = 0; i < 10; i++)
      send_cmd(CMD_READ, 0, 0, 0, 0, 12'($urandom_range(0, 40)));
    // hold the stream until every outstanding result has drained
    wait_idle();
    send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0);
    set_grid(0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= ($urandom_range(0, 7) > (n_items / 100) % 4 * 2);
  end

  always @(posedge clk_i) begin
    voxel_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tuser_o, m_axis_tdata_o[196:0]};
      got.status = m_axis_tuser_o;
      {got.voxel_total, got.agg_i, got.agg_z, got.agg_y, got.agg_x, got.point_count,
       got.coord_z, got.coord_y, got.coord_x, got.slot, got.voxel_index} =
        m_axis_tdata_o[196:0];
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status); errors++;
        end
        if (got.voxel_index != want.voxel_index) begin
          $error("voxel_index: expected %0d actual %0d", want.voxel_index, got.voxel_index);
          errors++;
        end
        if (got.slot != want.slot) begin
          $error("slot: expected %0d actual %0d", want.slot, got.slot); errors++;
        end
        if (got.coord_x != want.coord_x) begin
          $error("coord_x: expected %0d actual %0d", want.coord_x, got.coord_x); errors++;
        end
        if (got.coord_y != want.coord_y) begin
          $error("coord_y: expected %0d actual %0d", want.coord_y, got.coord_y); errors++;
        end
        if (got.coord_z != want.coord_z) begin
          $error("coord_z: expected %0d actual %0d", want.coord_z, got.coord_z); errors++;
        end
        if (got.point_count != want.point_count) begin
          $error("point_count: expected %0d actual %0d", want.point_count, got.point_count);
          errors++;
        end
        if (got.agg_x != want.agg_x) begin
          $error("agg_x: expected %h actual %h", want.agg_x, got.agg_x); errors++;
        end
        if (got.agg_y != want.agg_y) begin
          $error("agg_y: expected %h actual %h", want.agg_y, got.agg_y); errors++;
        end
        if (got.agg_z != want.agg_z) begin
          $error("agg_z: expected %h actual %h", want.agg_z, got.agg_z); errors++;
        end
        if (got.agg_i != want.agg_i) begin
          $error("agg_intensity: expected %h actual %h", want.agg_i, got.agg_i); errors++;
        end
        if (got.voxel_total != want.voxel_total) begin
          $error("voxel_total: expected %0d actual %0d", want.voxel_total, got.voxel_total);
          errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    org = '{default: 32'd0};
    inv = '{default: 32'h10000};
    mode = MODE_NONE;
    max_pts = 6'd32;
    n_alloc = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(130, MODE_MEAN, 6'd3);
    test_random(110, MODE_MAX, 6'd32);
    test_random(110, MODE_MIN, 6'd1);
    test_coarse_grid();
    test_random(80, MODE_NONE, 6'd20);
    wait_idle();
    repeat (200) @(posedge clk_i);
    $display("Ran %0d commands (insert, read, clear) over four reduction modes and",
             n_items);
    $display("several grid settings; %0d results checked.", n_results);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
